>>> rtl/core/suc_pkg.sv
// Shared types and constants for the substring occurrence counter.
// No dependencies; imported by every module of the block.
package suc_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 32;
    localparam int CFG_PAT_BYTES       = 32;
    localparam int CFG_PAT_REGS        = 4;
    localparam int PAT_IDX_W           = 5;
    localparam int LEN_W               = 6;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 64;
    localparam int COUNT_W             = 32;

    localparam logic [LEN_W-1:0] FILL_CAP    = 6'd63;
    localparam logic [LEN_W-1:0] LEN_RESET   = 6'd1;
    localparam logic [7:0]       BYTE_NUL     = 8'h00;
    localparam logic [7:0]       BYTE_NEWLINE = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LEN   = 3'd0,
        REG_PAT_0_7   = 3'd1,
        REG_PAT_8_15  = 3'd2,
        REG_PAT_16_23 = 3'd3,
        REG_PAT_24_31 = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [LEN_W-1:0]                  len;
        logic [CFG_PAT_BYTES-1:0][7:0]     pat;
    } t_cfg;

endpackage

>>> rtl/core/suc_cfg_regs.sv
// Configuration registers: pattern length (clamped) and pattern bytes.
// Depends on suc_pkg.
module suc_cfg_regs import suc_pkg::*; #(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [LEN_W-1:0]                        r_len;
    logic [CFG_PAT_REGS-1:0][CFG_DATA_W-1:0] r_pat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
            r_pat <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAT_LEN:   r_len    <= i_cfg_data[LEN_W-1:0];
                REG_PAT_0_7:   r_pat[0] <= i_cfg_data;
                REG_PAT_8_15:  r_pat[1] <= i_cfg_data;
                REG_PAT_16_23: r_pat[2] <= i_cfg_data;
                REG_PAT_24_31: r_pat[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if ({1'b0, r_len} > (LEN_W+1)'(MAX_PATTERN_LEN)) begin
            o_cfg.len = LEN_W'(MAX_PATTERN_LEN);
        end else begin
            o_cfg.len = r_len;
        end
        o_cfg.pat = r_pat;
    end

endmodule

>>> rtl/core/suc_match_unit.sv
// Parallel byte comparators: text window against the reversed pattern.
// Depends on suc_pkg.
module suc_match_unit import suc_pkg::*; #(
    parameter  int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
    localparam int HIST_DEPTH      = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1
) (
    input  logic [7:0]                 i_text_byte,
    input  logic [HIST_DEPTH-1:0][7:0] i_hist,
    input  t_cfg                       i_cfg,
    output logic                       o_equal
);

    logic [MAX_PATTERN_LEN-1:0] lane_ok;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_lane
        logic [7:0]       w_text;
        logic [LEN_W-1:0] w_pos;
        logic [7:0]       w_pat;

        if (k == 0) begin : g_head
            assign w_text = i_text_byte;
        end else begin : g_tail
            assign w_text = i_hist[k-1];
        end

        assign w_pos = i_cfg.len - LEN_W'(k) - LEN_W'(1);
        assign w_pat = (w_pos >= LEN_W'(CFG_PAT_BYTES)) ? BYTE_NUL
                                                        : i_cfg.pat[w_pos[PAT_IDX_W-1:0]];
        assign lane_ok[k] = (LEN_W'(k) >= i_cfg.len) || (w_text == w_pat);
    end

    assign o_equal = &lane_ok;

endmodule

>>> rtl/core/substring_occurrence_counter_top.sv
// Top level of the substring occurrence counter: input register, line state,
// match decision and result register. Depends on suc_pkg, suc_cfg_regs, suc_match_unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one text byte per beat with
//   an end-of-file flag on the last byte of a file. Output channel
//   (o_out_valid / i_out_stall) carries one occurrence count per file.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
//   pattern length (index 0) and the four pattern byte words (index 1 to 4);
//   write it only while no byte is in flight.
//   Throughput: one byte per cycle while no end-of-file byte waits. A byte sits
//   in the input register while the comparators and line logic evaluate it, and
//   the count of a file goes from there into the result register, which drives
//   o_occurrence_count.
//   When the receiver stalls, the count holds in the result register; bytes
//   that do not end a file keep flowing, and an end-of-file byte waits in the
//   input register, which stalls the input channel, until the result
//   register is free.
//   Reset: pattern length 1, pattern bytes zero, count and line state cleared,
//   both registers empty.
module substring_occurrence_counter_top import suc_pkg::*; #(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_end_of_file,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COUNT_W-1:0]    o_occurrence_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HIST_DEPTH = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;

    t_cfg cfg;

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_eof;
    logic                       r_out_valid;
    logic [COUNT_W-1:0]         r_out_count;
    logic [HIST_DEPTH-1:0][7:0] r_hist;
    logic [LEN_W-1:0]           r_fill;
    logic [LEN_W-1:0]           r_skip;
    logic                       r_hidden;
    logic [COUNT_W-1:0]         r_total;

    logic [HIST_DEPTH-1:0][7:0] n_hist;
    logic [LEN_W-1:0]           n_fill;
    logic [LEN_W-1:0]           n_skip;
    logic                       n_hidden;
    logic [COUNT_W-1:0]         n_total;

    logic equal;
    logic hit;
    logic advance;
    logic in_accept;
    logic out_take;

    suc_cfg_regs #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    suc_match_unit #(
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_match_unit (
        .i_text_byte (r_in_byte),
        .i_hist      (r_hist),
        .i_cfg       (cfg),
        .o_equal     (equal)
    );

    assign out_take   = r_out_valid && !i_out_stall;
    assign advance    = r_in_valid && (!r_in_eof || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid        = r_out_valid;
    assign o_occurrence_count = r_out_count;

    always_comb begin
        n_hidden = r_hidden || (r_in_byte == BYTE_NUL);
        n_fill   = (r_fill < FILL_CAP) ? r_fill + LEN_W'(1) : r_fill;
        hit      = (r_skip == '0) && !n_hidden && (cfg.len != '0)
                   && (n_fill >= cfg.len) && equal;
        n_total  = r_total;
        if (r_skip != '0) begin
            n_skip = r_skip - LEN_W'(1);
        end else if (hit) begin
            n_skip = cfg.len - LEN_W'(1);
        end else begin
            n_skip = r_skip;
        end
        if (hit && (r_total != '1)) begin
            n_total = r_total + COUNT_W'(1);
        end
        n_hist[0] = r_in_byte;
        for (int i = 1; i < HIST_DEPTH; i++) begin
            n_hist[i] = r_hist[i-1];
        end
        if (r_in_byte == BYTE_NEWLINE) begin
            n_fill   = '0;
            n_skip   = '0;
            n_hidden = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_text_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    // line and file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_fill   <= '0;
            r_skip   <= '0;
            r_hidden <= 1'b0;
            r_total  <= '0;
        end else if (advance) begin
            if (r_in_eof) begin
                r_hist   <= '0;
                r_fill   <= '0;
                r_skip   <= '0;
                r_hidden <= 1'b0;
                r_total  <= '0;
            end else begin
                r_hist   <= n_hist;
                r_fill   <= n_fill;
                r_skip   <= n_skip;
                r_hidden <= n_hidden;
                r_total  <= n_total;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_eof) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_eof) begin
            r_out_count <= n_total;
        end
    end

    a_eof_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_eof |=> r_total == '0 && r_fill == '0 && r_skip == '0 && !r_hidden)
        else $error("file state not cleared after end of file");

    a_result_from_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance && r_in_eof))
        else $error("result raised without an end-of-file byte");

    a_eof_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_eof && r_out_valid && i_out_stall |=> r_in_valid && r_in_eof)
        else $error("end-of-file byte lost while result stalled");

    a_hit_sets_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && hit && !r_in_eof && (r_in_byte != BYTE_NEWLINE)
        |=> r_skip == $past(cfg.len) - LEN_W'(1))
        else $error("skip count not loaded after a match");

endmodule

>>> dv/substring_occurrence_counter_top_tb.sv
`timescale 1ns / 100ps
// Testbench for substring_occurrence_counter_top: streams text files through the byte channel,
// reprograms the search pattern between phases and checks every per-file occurrence count.
// Depends on suc_pkg and the counter RTL; predicts counts with its own scan of the text.
module substring_occurrence_counter_top_tb;
    import suc_pkg::*;

    localparam int unsigned NUM_PHASES      = 16;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned HOLD_PHASE      = 10;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned REG_SPARE_LO    = 5;
    localparam int unsigned REG_SPARE_HI    = 7;
    localparam logic [7:0]  CH_A            = 8'h61;
    localparam logic [7:0]  CH_B            = 8'h62;
    localparam logic [7:0]  CH_X            = 8'h78;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_text_beat;

    logic                  i_clk;
    logic                  i_rst_n            = 1'b0;
    logic                  i_in_valid         = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_text_byte        = '0;
    logic                  i_end_of_file      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall        = 1'b0;
    logic [COUNT_W-1:0]    o_occurrence_count;
    logic                  i_cfg_valid        = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;

    substring_occurrence_counter_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_text_byte        (i_text_byte),
        .i_end_of_file      (i_end_of_file),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_occurrence_count (o_occurrence_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // pattern image and scan state of the counter
    logic [LEN_W-1:0]                pat_len_reg = LEN_RESET;
    logic [CFG_PAT_REGS*CFG_DATA_W-1:0] pat_img  = '0;
    logic [7:0]   line_window [MAX_PATTERN_LEN_DEF] = '{default: '0};
    int unsigned  line_fill    = 0;
    int unsigned  skip_left    = 0;
    bit           line_has_nul = 1'b0;
    logic [COUNT_W-1:0] file_hits = '0;

    t_text_beat         text_q[$];
    logic [COUNT_W-1:0] count_q[$];
    t_text_beat         next_beat;
    logic [COUNT_W-1:0] want_count;
    int unsigned        items_queued   = 0;
    int unsigned        mismatch_cnt   = 0;
    int unsigned        cycle_cnt      = 0;
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    bit                 out_hold_go    = 1'b0;
    int unsigned        hold_cycles    = 0;

    function automatic logic [7:0] pattern_byte(input int unsigned j);
        if (j >= CFG_PAT_BYTES) return '0;
        return pat_img[8*j +: 8];
    endfunction

    function automatic int unsigned eff_pattern_len();
        if (pat_len_reg > MAX_PATTERN_LEN_DEF) return MAX_PATTERN_LEN_DEF;
        return pat_len_reg;
    endfunction

    function automatic void clear_line();
        line_fill    = 0;
        skip_left    = 0;
        line_has_nul = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic eof);
        int unsigned len;
        int unsigned k;
        bit hit;
        len = eff_pattern_len();
        if (b == BYTE_NUL) line_has_nul = 1'b1;
        if (line_fill < FILL_CAP) line_fill++;
        if (skip_left > 0) begin
            skip_left--;
        end else if (!line_has_nul && len > 0 && line_fill >= len) begin
            hit = (b == pattern_byte(len - 1));
            for (k = 1; k < len; k++) begin
                if (line_window[k-1] != pattern_byte(len - 1 - k)) hit = 1'b0;
            end
            if (hit) begin
                if (file_hits != '1) file_hits++;
                skip_left = len - 1;
            end
        end
        for (k = MAX_PATTERN_LEN_DEF - 1; k > 0; k--) line_window[k] = line_window[k-1];
        line_window[0] = b;
        if (b == BYTE_NEWLINE) clear_line();
        if (eof) begin
            count_q.push_back(file_hits);
            file_hits = '0;
            clear_line();
            for (k = 0; k < MAX_PATTERN_LEN_DEF; k++) line_window[k] = '0;
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        $display("ERROR %0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic eof);
        t_text_beat beat;
        beat.data = b;
        beat.eof  = eof;
        text_q.push_back(beat);
        items_queued++;
    endfunction

    task automatic add_file(input int unsigned n, input int unsigned nl_pct, input bit close);
        int unsigned eff;
        int unsigned cnt;
        int unsigned r;
        int unsigned j;
        logic [7:0]  b;
        t_text_beat  tail;
        eff = eff_pattern_len();
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 25 && eff > 0) begin
                for (j = 0; j < eff; j++) begin
                    b = pattern_byte(j);
                    if ($urandom_range(9) == 0) b = 8'($urandom);
                    queue_byte(b, 1'b0);
                end
                cnt += eff;
            end else begin
                if (r < 25 + nl_pct) b = BYTE_NEWLINE;
                else if (r < 28 + nl_pct) b = BYTE_NUL;
                else if (r < 80) b = (eff > 0) ? pattern_byte($urandom_range(eff - 1)) : CH_A;
                else b = 8'($urandom);
                queue_byte(b, 1'b0);
                cnt++;
            end
        end
        if (close) begin
            tail = text_q.pop_back();
            tail.eof = 1'b1;
            text_q.push_back(tail);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_PAT_LEN:   pat_len_reg = data[LEN_W-1:0];
            REG_PAT_0_7:   pat_img[0*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PAT_8_15:  pat_img[1*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PAT_16_23: pat_img[2*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PAT_24_31: pat_img[3*CFG_DATA_W +: CFG_DATA_W] = data;
            default: ;
        endcase
    endtask

    task automatic set_pattern(input logic [LEN_W-1:0] len,
                               input logic [CFG_PAT_REGS*CFG_DATA_W-1:0] img);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        @(posedge i_clk);
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), {$urandom, $urandom});
        write_reg(REG_PAT_0_7,   img[0*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_8_15,  img[1*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_16_23, img[2*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_24_31, img[3*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_LEN,   len_word);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        while (text_q.size() != 0 || i_in_valid || count_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic int unsigned phase_length(input int unsigned p);
        case (p)
            0: return 1;    1: return 2;    2: return 3;    3: return 6;
            4: return 0;    5: return 5;    6: return 32;   7: return 63;
            8: return 4;    9: return 8;    10: return 2;   11: return 16;
            12: return 33;  13: return 31;  14: return 3;   default: return 7;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) scan_byte(i_text_byte, i_end_of_file);
            if (!i_in_valid || !o_in_stall) begin
                if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = text_q.pop_front();
                    i_text_byte   <= next_beat.data;
                    i_end_of_file <= next_beat.eof;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // count receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles <= 0;
        end else if (out_hold_go && hold_cycles < LONG_HOLD) begin
            hold_cycles <= hold_cycles + 1;
            i_out_stall <= 1'b1;
        end else begin
            if (!out_hold_go) hold_cycles <= 0;
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // count monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (count_q.size() == 0) begin
                flag_mismatch("occurrence_count with no file pending", o_occurrence_count, '0);
            end else begin
                want_count = count_q.pop_front();
                if (o_occurrence_count !== want_count)
                    flag_mismatch("occurrence_count", o_occurrence_count, want_count);
            end
        end
    end

    initial begin
        int unsigned p;
        int unsigned j;
        int unsigned r;
        int unsigned eff;
        int unsigned target;
        logic [CFG_PAT_REGS*CFG_DATA_W-1:0] img;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pattern is a single zero byte: nothing may match
        @(negedge i_clk);
        queue_byte(BYTE_NUL, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(BYTE_NEWLINE, 1'b0);
        queue_byte(BYTE_NUL, 1'b1);
        drain_all();

        img = '0;
        img[15:0] = {CH_A, CH_A};
        set_pattern(6'd2, img);
        @(negedge i_clk);
        queue_byte(CH_A, 1'b0);
        queue_byte(CH_A, 1'b0);
        queue_byte(CH_A, 1'b0);
        queue_byte(BYTE_NEWLINE, 1'b0);
        queue_byte(CH_A, 1'b0);
        queue_byte(CH_A, 1'b1);
        queue_byte(CH_X, 1'b0);
        queue_byte(CH_A, 1'b0);
        drain_all();

        // change pattern mid-line
        img = '0;
        img[7:0] = CH_A;
        set_pattern(6'd1, img);
        @(negedge i_clk);
        queue_byte(CH_A, 1'b0);
        queue_byte(CH_A, 1'b1);
        drain_all();

        set_pattern(6'd0, img);
        @(negedge i_clk);
        queue_byte(CH_A, 1'b0);
        queue_byte(CH_A, 1'b1);
        drain_all();

        target = items_queued;
        for (p = 0; p < NUM_PHASES; p++) begin
            eff = phase_length(p);
            if (eff > MAX_PATTERN_LEN_DEF) eff = MAX_PATTERN_LEN_DEF;
            for (j = 0; j < CFG_PAT_BYTES; j++) begin
                if (p % 4 == 1 || j >= eff) img[8*j +: 8] = 8'($urandom);
                else img[8*j +: 8] = ($urandom_range(1) != 0) ? CH_B : CH_A;
            end
            if (p % 5 == 3 && eff > 1) img[8*$urandom_range(eff - 1) +: 8] = BYTE_NUL;
            if (p % 5 == 4 && eff > 0) img[8*(eff - 1) +: 8] = BYTE_NEWLINE;
            set_pattern(LEN_W'(phase_length(p)), img);

            @(negedge i_clk);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (p == HOLD_PHASE) out_hold_go = 1'b1;
            target += ITEMS_PER_PHASE;
            while (items_queued < target) begin
                r = $urandom_range(9);
                if (p == HOLD_PHASE) add_file($urandom_range(3, 1), 8, 1'b1);
                else if (r == 0) add_file($urandom_range(90, 64), 0, 1'b1);
                else if (r < 3) add_file($urandom_range(40, 13), 8, 1'b1);
                else add_file($urandom_range(12, 1), 8, 1'b1);
            end
            // leave a file open across the next pattern change
            if ($urandom_range(1) != 0) add_file($urandom_range(6, 1), 8, 1'b0);
            drain_all();
            out_hold_go = 1'b0;
        end

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
